@@ rtl/nfpa_pkg.sv @@
// Shared constants, codes, types and helper functions of the next-fit page allocator.
`timescale 1ns / 1ps
`default_nettype none

package nfpa_pkg;

    // Bitmap geometry: one memory row holds the allocated bits of WORD_BITS pages.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    // Default sizing of the allocator.
    localparam int DEF_MAX_PAGES  = 65536;
    localparam int DEF_PAGE_BYTES = 4096;

    // Fixed field widths of the stream items and the register.
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 40;
    localparam int IDX_W   = 16;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 17;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
    localparam logic [OP_W-1:0] OP_USABLE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CURSOR  = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNALIGNED = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DOUBLE    = 3'd4;

    // Row unit modes.
    localparam logic [1:0] MODE_FIND  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W:0]   hi_cnt;
        logic [BIT_W-1:0] pos;
    } t_unit_req;

    typedef struct packed {
        logic                 found;
        logic [BIT_W-1:0]     first;
        logic                 bit_val;
        logic [WORD_BITS-1:0] row_out;
    } t_unit_rsp;

    function automatic int row_count(input int max_pages);
        return (max_pages + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic int row_width(input int max_pages);
        int rows;
        rows = row_count(max_pages);
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nfpa_map_ram.sv @@
// Bitmap memory: one row of page bits per address, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nfpa_map_ram #(
    parameter int MAX_PAGES = nfpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [nfpa_pkg::row_width(MAX_PAGES)-1:0]  i_wr_row,
    input  wire logic [nfpa_pkg::WORD_BITS-1:0]             i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [nfpa_pkg::row_width(MAX_PAGES)-1:0]  i_rd_row,
    output logic      [nfpa_pkg::WORD_BITS-1:0]             o_rd_data
);
    import nfpa_pkg::*;

    localparam int ROWS = row_count(MAX_PAGES);

    logic [WORD_BITS-1:0] r_mem [ROWS];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/nfpa_row_unit.sv @@
// Shared row unit: finds the first free page of a row in a bit window and sets or clears bits.
`timescale 1ns / 1ps
`default_nettype none

module nfpa_row_unit (
    input  wire nfpa_pkg::t_unit_req                 i_req,
    input  wire logic [nfpa_pkg::WORD_BITS-1:0]      i_row,
    output nfpa_pkg::t_unit_rsp                      o_rsp
);
    import nfpa_pkg::*;

    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;
    logic [WORD_BITS-1:0] pos_hot;
    logic [BIT_W-1:0]     first;
    logic [WORD_BITS-1:0] row_out;

    // A candidate is a free bit inside [lo_bit, hi_cnt).
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = !i_row[b] && ((BIT_W+1)'(b) >= {1'b0, i_req.lo_bit})
                      && ((BIT_W+1)'(b) < i_req.hi_cnt);
        end
    end

    // Isolate the lowest candidate, then encode it.
    assign lowest = cand & (~cand + WORD_BITS'(1));

    always_comb begin
        first = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            first = first | (lowest[b] ? BIT_W'(b) : '0);
        end
    end

    assign pos_hot = WORD_BITS'(1) << i_req.pos;

    always_comb begin
        unique case (i_req.mode)
            MODE_FIND:  row_out = i_row | lowest;
            MODE_SET:   row_out = i_row | pos_hot;
            MODE_CLEAR: row_out = i_row & ~pos_hot;
            default:    row_out = i_row;
        endcase
    end

    assign o_rsp.found   = |cand;
    assign o_rsp.first   = first;
    assign o_rsp.bit_val = i_row[i_req.pos];
    assign o_rsp.row_out = row_out;

endmodule

`default_nettype wire

@@ rtl/nfpa_ctrl.sv @@
// Sequencer of the allocator: decodes operations, walks bitmap rows and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none

module nfpa_ctrl #(
    parameter int MAX_PAGES  = nfpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = nfpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_ready,
    input  wire logic [nfpa_pkg::OP_W-1:0]                  i_opcode,
    input  wire logic [nfpa_pkg::ADDR_W-1:0]                i_address,
    input  wire logic [nfpa_pkg::IDX_W-1:0]                 i_page_index,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_ready,
    output logic      [nfpa_pkg::STAT_W-1:0]                o_status,
    output logic      [nfpa_pkg::ADDR_W-1:0]                o_page_address,
    output logic      [nfpa_pkg::COUNT_W-1:0]               o_free_count,
    input  wire logic [nfpa_pkg::COUNT_W-1:0]               i_tracked_pages,
    output logic                                            o_ram_wr_en,
    output logic      [nfpa_pkg::row_width(MAX_PAGES)-1:0]  o_ram_wr_row,
    output logic      [nfpa_pkg::WORD_BITS-1:0]             o_ram_wr_data,
    output logic                                            o_ram_rd_en,
    output logic      [nfpa_pkg::row_width(MAX_PAGES)-1:0]  o_ram_rd_row,
    output nfpa_pkg::t_unit_req                             o_unit_req,
    input  wire nfpa_pkg::t_unit_rsp                        i_unit_rsp
);
    import nfpa_pkg::*;

    localparam int ROWS       = row_count(MAX_PAGES);
    localparam int ROW_W      = row_width(MAX_PAGES);
    localparam int PG_W       = ROW_W + BIT_W;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int CMP_W      = PG_W + 1;
    localparam int IXC_W      = (CMP_W > IDX_W) ? CMP_W : IDX_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PGN_W      = ADDR_W - PAGE_SHIFT;
    localparam int ADC_W      = (PGN_W > CMP_W) ? PGN_W : CMP_W;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN_RD = 3'd2;
    localparam logic [2:0] S_SCAN_EV = 3'd3;
    localparam logic [2:0] S_MOD_RD  = 3'd4;
    localparam logic [2:0] S_MOD_EV  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // Control state.
    logic [2:0]       r_state,     n_state;
    logic [ROW_W-1:0] r_row,       n_row;
    logic [PG_W-1:0]  r_cursor,    n_cursor;
    logic [CNT_W-1:0] r_free,      n_free;
    logic             r_out_valid, n_out_valid;

    // Per-item working registers.
    logic [OP_W-1:0]   r_op,      n_op;
    logic [CNT_W-1:0]  r_n,       n_n;
    logic [PG_W-1:0]   r_target,  n_target;
    logic              r_phase,   n_phase;
    logic [PG_W-1:0]   r_p0,      n_p0;
    logic [ROW_W-1:0]  r_lo_row,  n_lo_row;
    logic [BIT_W-1:0]  r_lo_bit,  n_lo_bit;
    logic [CMP_W-1:0]  r_hi,      n_hi;
    logic [ROW_W-1:0]  r_hi_row,  n_hi_row;
    logic [STAT_W-1:0] r_status,  n_status;
    logic [ADDR_W-1:0] r_got,     n_got;
    logic [STAT_W-1:0] r_out_status;
    logic [ADDR_W-1:0] r_out_addr;
    logic [CNT_W-1:0]  r_out_free;
    logic              out_load;

    // Decode of the incoming beat.
    logic [CNT_W-1:0]  live_n;
    logic [CMP_W-1:0]  n_ext;
    logic [CMP_W-1:0]  nm1;
    logic [PG_W-1:0]   p0;
    logic [IXC_W-1:0]  idx_ext;
    logic              idx_bad;
    logic [PG_W-1:0]   idx_page;
    logic [ADC_W-1:0]  pgn_ext;
    logic              addr_bad;
    logic              unaligned;
    logic [PG_W-1:0]   addr_page;

    // Scan evaluation.
    logic [CMP_W-1:0]  row_base;
    logic [CMP_W-1:0]  hi_diff;
    logic [BIT_W:0]    hi_cnt;
    logic [BIT_W-1:0]  lo_bit_cur;
    logic [PG_W-1:0]   found_pg;
    logic [CMP_W-1:0]  found_next;
    logic [PG_W-1:0]   pm1;
    logic [31:0]       free_wide;

    always_comb begin
        if ({15'd0, i_tracked_pages} >= 32'(MAX_PAGES)) begin
            live_n = CNT_W'(MAX_PAGES);
        end else begin
            live_n = CNT_W'(i_tracked_pages);
        end
    end

    assign n_ext     = CMP_W'(live_n);
    assign nm1       = n_ext - CMP_W'(1);
    assign p0        = (CMP_W'(r_cursor) < n_ext) ? r_cursor : '0;
    assign idx_ext   = IXC_W'(i_page_index);
    assign idx_bad   = idx_ext >= IXC_W'(live_n);
    assign idx_page  = idx_ext[PG_W-1:0];
    assign pgn_ext   = ADC_W'(i_address[ADDR_W-1:PAGE_SHIFT]);
    assign addr_bad  = pgn_ext >= ADC_W'(live_n);
    assign unaligned = |i_address[PAGE_SHIFT-1:0];
    assign addr_page = pgn_ext[PG_W-1:0];

    assign row_base   = CMP_W'({r_row, BIT_W'(0)});
    assign hi_diff    = r_hi - row_base;
    assign hi_cnt     = (hi_diff >= CMP_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
                                                       : hi_diff[BIT_W:0];
    assign lo_bit_cur = (r_row == r_lo_row) ? r_lo_bit : '0;
    assign found_pg   = {r_row, i_unit_rsp.first};
    assign found_next = CMP_W'(found_pg) + CMP_W'(1);
    assign pm1        = r_p0 - PG_W'(1);

    // Shared row unit requests.
    always_comb begin
        o_unit_req.mode   = MODE_FIND;
        o_unit_req.lo_bit = lo_bit_cur;
        o_unit_req.hi_cnt = hi_cnt;
        o_unit_req.pos    = r_target[BIT_W-1:0];
        if (r_state == S_MOD_EV) begin
            o_unit_req.mode = (r_op == OP_RESERVE) ? MODE_SET : MODE_CLEAR;
        end
    end

    assign o_ram_rd_en   = (r_state == S_SCAN_RD) || (r_state == S_MOD_RD);
    assign o_ram_rd_row  = (r_state == S_MOD_RD) ? r_target[PG_W-1:BIT_W] : r_row;
    assign o_ram_wr_row  = (r_state == S_MOD_EV) ? r_target[PG_W-1:BIT_W] : r_row;
    assign o_ram_wr_data = (r_state == S_CLEAR) ? '1 : i_unit_rsp.row_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_cursor    = r_cursor;
        n_free      = r_free;
        n_op        = r_op;
        n_n         = r_n;
        n_target    = r_target;
        n_phase     = r_phase;
        n_p0        = r_p0;
        n_lo_row    = r_lo_row;
        n_lo_bit    = r_lo_bit;
        n_hi        = r_hi;
        n_hi_row    = r_hi_row;
        n_status    = r_status;
        n_got       = r_got;
        o_ram_wr_en = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_wr_en = 1'b1;
                n_row       = r_row + ROW_W'(1);
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_n      = live_n;
                    n_status = ST_OK;
                    n_got    = '0;
                    n_state  = S_DONE;
                    case (i_opcode)
                        OP_ALLOC: begin
                            if (live_n == '0) begin
                                n_status = ST_EXHAUSTED;
                            end else begin
                                n_phase  = 1'b0;
                                n_p0     = p0;
                                n_row    = p0[PG_W-1:BIT_W];
                                n_lo_row = p0[PG_W-1:BIT_W];
                                n_lo_bit = p0[BIT_W-1:0];
                                n_hi     = n_ext;
                                n_hi_row = nm1[PG_W-1:BIT_W];
                                n_state  = S_SCAN_RD;
                            end
                        end
                        OP_FREE: begin
                            priority if (unaligned) begin
                                n_status = ST_UNALIGNED;
                            end else if (addr_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_target = addr_page;
                                n_state  = S_MOD_RD;
                            end
                        end
                        OP_USABLE: begin
                            priority if (idx_bad) begin
                                n_status = ST_RANGE;
                            end else if (i_page_index != '0) begin
                                n_target = idx_page;
                                n_state  = S_MOD_RD;
                            end else begin
                                n_status = ST_OK;
                            end
                        end
                        OP_RESERVE: begin
                            if (idx_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_target = idx_page;
                                n_state  = S_MOD_RD;
                            end
                        end
                        OP_CURSOR: begin
                            if (idx_bad) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_cursor = idx_page;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                priority if (i_unit_rsp.found) begin
                    o_ram_wr_en = 1'b1;
                    n_free      = r_free - CNT_W'(1);
                    n_cursor    = (found_next == CMP_W'(r_n)) ? '0 : found_next[PG_W-1:0];
                    n_got       = ADDR_W'(found_pg) << PAGE_SHIFT;
                    n_state     = S_DONE;
                end else if (r_row == r_hi_row) begin
                    if (!r_phase && (r_p0 != '0)) begin
                        // Wrap around: scan the pages below the start point.
                        n_phase  = 1'b1;
                        n_row    = '0;
                        n_lo_row = '0;
                        n_lo_bit = '0;
                        n_hi     = CMP_W'(r_p0);
                        n_hi_row = pm1[PG_W-1:BIT_W];
                        n_state  = S_SCAN_RD;
                    end else begin
                        n_status = ST_EXHAUSTED;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_MOD_RD: begin
                n_state = S_MOD_EV;
            end
            S_MOD_EV: begin
                n_state = S_DONE;
                case (r_op)
                    OP_FREE: begin
                        if (!i_unit_rsp.bit_val) begin
                            n_status = ST_DOUBLE;
                        end else begin
                            o_ram_wr_en = 1'b1;
                            n_free      = r_free + CNT_W'(1);
                        end
                    end
                    OP_USABLE: begin
                        if (i_unit_rsp.bit_val) begin
                            o_ram_wr_en = 1'b1;
                            n_free      = r_free + CNT_W'(1);
                        end
                    end
                    OP_RESERVE: begin
                        if (!i_unit_rsp.bit_val) begin
                            o_ram_wr_en = 1'b1;
                            n_free      = r_free - CNT_W'(1);
                        end
                    end
                    default: begin
                        n_status = r_status;
                    end
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_cursor    <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_cursor    <= n_cursor;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_n      <= n_n;
        r_target <= n_target;
        r_phase  <= n_phase;
        r_p0     <= n_p0;
        r_lo_row <= n_lo_row;
        r_lo_bit <= n_lo_bit;
        r_hi     <= n_hi;
        r_hi_row <= n_hi_row;
        r_status <= n_status;
        r_got    <= n_got;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_got;
            r_out_free   <= r_free;
        end
    end

    assign free_wide      = 32'(r_out_free);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_page_address = r_out_addr;
    assign o_free_count   = free_wide[COUNT_W-1:0];

    // The free count can never exceed the number of pages the bitmap holds.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(MAX_PAGES))
        else $error("free page count above bitmap size");

    // An accepted beat always starts work; the sequencer leaves idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat left the sequencer idle");

    // The bitmap is only written while clearing or when a row is evaluated.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_wr_en |-> (r_state == S_CLEAR || r_state == S_SCAN_EV || r_state == S_MOD_EV))
        else $error("bitmap write outside a write phase");

    // The scan never walks past the last row of its window.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EV) |-> (r_row <= r_hi_row))
        else $error("scan row beyond window");

endmodule

`default_nettype wire

@@ rtl/next_fit_page_bitmap_allocator.sv @@
// Top level of the next-fit page bitmap allocator: register port, stream packing, submodules.
`timescale 1ns / 1ps
`default_nettype none

// The allocator keeps one bit per page (set = allocated or reserved) in a memory of
// 32-page rows, together with a free-page count and a next-fit cursor. Each beat on the
// input stream carries one operation: allocate, free by byte address, make a page usable,
// reserve a page, or set the cursor. Each operation produces exactly one result beat with
// a status, the byte address of an allocated page (zero otherwise) and the free count.
// After reset the block runs a clearing pass that marks every page reserved, one row per
// cycle; no beat is accepted during that pass, while register writes are taken at any time.
// The block takes one beat at a time. An allocate walks the bitmap row by row, because
// the bitmap memory has one registered read port and each row is read, then evaluated by
// the shared row unit; a scan that finds nothing visits every tracked row, up to
// ceil(tracked_pages / 32) + 1 rows. A free, make-usable or reserve is a read-modify-write
// of one row, but a make-usable of page 0 touches no row; rejected operations, set-cursor
// and unknown codes do not touch the bitmap. A finished result sits in an output register,
// and the next beat is taken while it waits, but a further result is held until that one
// is taken.
// The tracked_pages register lies at byte address 0 of the register port and resets to
// 65536; pages at or above it are never handed out. PAGE_BYTES must be a power of two.
module next_fit_page_bitmap_allocator #(
    parameter int MAX_PAGES  = nfpa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = nfpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Operation beats.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // opcode[2:0], address[42:3], page_index[58:43]
    // Result beats.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [63:0] o_m_axis_tdata,   // status[2:0], page_address[42:3], free_count[59:43]
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import nfpa_pkg::*;

    localparam int ROW_W = row_width(MAX_PAGES);

    // Register index decoded from the word address.
    localparam logic REG_TRACKED = 1'b0;

    logic [COUNT_W-1:0]   r_tracked_pages;
    logic                 cfg_write;

    logic [STAT_W-1:0]    status;
    logic [ADDR_W-1:0]    page_address;
    logic [COUNT_W-1:0]   free_count;

    logic                 ram_wr_en;
    logic [ROW_W-1:0]     ram_wr_row;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [ROW_W-1:0]     ram_rd_row;
    logic [WORD_BITS-1:0] ram_rd_data;
    t_unit_req            unit_req;
    t_unit_rsp            unit_rsp;

    // The register port never stalls; a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked_pages <= COUNT_W'(65536);
        end else if (cfg_write && (paddr[2] == REG_TRACKED)) begin
            r_tracked_pages <= pwdata[COUNT_W-1:0];
        end
    end

    // Byte lanes in paddr[1:0] are ignored; only word addresses decode.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TRACKED) begin
            prdata = {{(32-COUNT_W){1'b0}}, r_tracked_pages};
        end
    end

    nfpa_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_s_axis_tvalid),
        .o_in_ready      (o_s_axis_tready),
        .i_opcode        (i_s_axis_tdata[2:0]),
        .i_address       (i_s_axis_tdata[42:3]),
        .i_page_index    (i_s_axis_tdata[58:43]),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_status        (status),
        .o_page_address  (page_address),
        .o_free_count    (free_count),
        .i_tracked_pages (r_tracked_pages),
        .o_ram_wr_en     (ram_wr_en),
        .o_ram_wr_row    (ram_wr_row),
        .o_ram_wr_data   (ram_wr_data),
        .o_ram_rd_en     (ram_rd_en),
        .o_ram_rd_row    (ram_rd_row),
        .o_unit_req      (unit_req),
        .i_unit_rsp      (unit_rsp)
    );

    nfpa_map_ram #(
        .MAX_PAGES (MAX_PAGES)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_row  (ram_wr_row),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_row  (ram_rd_row),
        .o_rd_data (ram_rd_data)
    );

    nfpa_row_unit u_row_unit (
        .i_req (unit_req),
        .i_row (ram_rd_data),
        .o_rsp (unit_rsp)
    );

    assign o_m_axis_tdata = {4'd0, free_count, page_address, status};

endmodule

`default_nettype wire
